// ----- rtl/sbg_pkg.sv -----
`timescale 1ns / 1ps

package sbg_pkg;

  localparam int unsigned AMP_W   = 24;
  localparam int unsigned PHASE_W = 24;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned THR_W   = 24;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned TDATA_W = AMP_W + PHASE_W;

  // Q1.16 unity gain
  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1 << FRAC_W);
  localparam logic [GAIN_W-1:0] GAIN_ZERO = '0;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_DECAY     = 2'd2
  } reg_idx_e;

endpackage

// ----- rtl/sbg_gain_store.sv -----
`timescale 1ns / 1ps

module sbg_gain_store
  import sbg_pkg::*;
#(
  parameter int unsigned MAX_BINS = 1024,
  parameter int unsigned IDX_W    = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_idx_i,
  input  logic [GAIN_W-1:0] wr_gain_i,
  output logic [GAIN_W-1:0] gain_o
);

  localparam int unsigned FILL_W = $clog2(MAX_BINS + 1);

  logic [GAIN_W-1:0] mem [MAX_BINS];
  logic [GAIN_W-1:0] rdata_q;
  logic [GAIN_W-1:0] byp_gain_q;
  logic              byp_hit_q;
  logic              rd_valid_q;
  logic [FILL_W-1:0] fill_q, fill_d;

  // Bins are always visited in order from 0, so the written entries form a
  // prefix of the store; anything at or past the fill count still reads zero.
  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && (FILL_W'(wr_idx_i) == fill_q)) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_gain_i;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_idx_i];
      byp_gain_q <= wr_gain_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      byp_hit_q  <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (rd_en_i) begin
        // same-edge write to the entry being read: array returns the old value
        byp_hit_q  <= wr_en_i && (wr_idx_i == rd_idx_i);
        rd_valid_q <= FILL_W'(rd_idx_i) < fill_q;
      end
    end
  end

  assign gain_o = byp_hit_q  ? byp_gain_q :
                  rd_valid_q ? rdata_q    : GAIN_ZERO;

endmodule

// ----- rtl/spectral_bin_gate.sv -----
`timescale 1ns / 1ps

// Per-bin spectral noise gate. Takes one bin per clock on the slave stream and
// returns one gated bin per clock on the master stream unless it stalls, each
// through the input stage (gain-store read) and the result register. Each
// bin keeps a Q1.16 gain that ramps up by attack_step while the amplitude is
// above threshold and down by decay_step otherwise, clamped to 0..1.0; the
// output amplitude is (amplitude * gain) >> 16 and the phase and tlast pass
// through. The gain store is a single-port-per-direction RAM with one
// read-modify-write per bin; back-to-back hits on the same bin are forwarded.
// A fill count makes unwritten bins read as zero gain, so there is no clearing
// pass after reset and bins fade in. The bin counter returns to 0 after a bin
// with tlast set and wraps after MAX_BINS bins. Registers: threshold at 0x0,
// attack_step at 0x4, decay_step at 0x8; write them only while the stream idles.

module spectral_bin_gate
  import sbg_pkg::*;
#(
  parameter int unsigned MAX_BINS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // slave stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // [23:0] amplitude, [47:24] phase
  input  logic               s_axis_tlast,  // last_bin
  // master stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // [23:0] gated_amplitude, [47:24] phase_out
  output logic               m_axis_tlast,  // last_out
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned IDX_W = $clog2(MAX_BINS);

  // configuration registers
  logic [THR_W-1:0]  threshold_q;
  logic [GAIN_W-1:0] attack_q;
  logic [GAIN_W-1:0] decay_q;
  logic              cfg_wr;
  reg_idx_e          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      attack_q    <= GAIN_ONE;
      decay_q     <= GAIN_ONE;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
        REG_ATTACK:    attack_q    <= pwdata[GAIN_W-1:0];
        REG_DECAY:     decay_q     <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_THRESHOLD: prdata = APB_DW'(threshold_q);
      REG_ATTACK:    prdata = APB_DW'(attack_q);
      REG_DECAY:     prdata = APB_DW'(decay_q);
      default:       prdata = '0;
    endcase
  end

  // pipeline control
  logic s1_valid_q;
  logic out_valid_q;
  logic s_fire;
  logic s1_adv;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  // bin counter
  logic [IDX_W-1:0] bin_idx_q, bin_idx_d;

  always_comb begin
    priority if (s_axis_tlast) begin
      bin_idx_d = '0;
    end else if (bin_idx_q == IDX_W'(MAX_BINS - 1)) begin
      bin_idx_d = '0;
    end else begin
      bin_idx_d = bin_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bin_idx_q   <= '0;
    end else begin
      if (s_fire) begin
        s1_valid_q <= 1'b1;
        bin_idx_q  <= bin_idx_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input stage payload
  logic [AMP_W-1:0]   s1_amp_q;
  logic [PHASE_W-1:0] s1_phase_q;
  logic               s1_last_q;
  logic [IDX_W-1:0]   s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_amp_q   <= s_axis_tdata[AMP_W-1:0];
      s1_phase_q <= s_axis_tdata[AMP_W +: PHASE_W];
      s1_last_q  <= s_axis_tlast;
      s1_idx_q   <= bin_idx_q;
    end
  end

  // gain update
  logic [GAIN_W-1:0] gain_old;
  logic [GAIN_W-1:0] gain_new;
  logic [GAIN_W:0]   gain_sum;
  logic              above;

  sbg_gain_store #(
    .MAX_BINS (MAX_BINS),
    .IDX_W    (IDX_W)
  ) u_gain_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s_fire),
    .rd_idx_i  (bin_idx_q),
    .wr_en_i   (s1_adv),
    .wr_idx_i  (s1_idx_q),
    .wr_gain_i (gain_new),
    .gain_o    (gain_old)
  );

  assign above    = s1_amp_q > threshold_q;
  assign gain_sum = {1'b0, gain_old} + {1'b0, attack_q};

  always_comb begin
    if (above) begin
      if (gain_old >= GAIN_ONE) begin
        gain_new = gain_old;
      end else if (gain_sum > {1'b0, GAIN_ONE}) begin
        gain_new = GAIN_ONE;
      end else begin
        gain_new = gain_sum[GAIN_W-1:0];
      end
    end else begin
      if (gain_old > decay_q) begin
        gain_new = gain_old - decay_q;
      end else begin
        gain_new = GAIN_ZERO;
      end
    end
  end

  // result register
  logic [AMP_W+GAIN_W-1:0] prod;
  logic [AMP_W-1:0]        out_amp_q;
  logic [PHASE_W-1:0]      out_phase_q;
  logic                    out_last_q;

  assign prod = (AMP_W + GAIN_W)'(s1_amp_q) * (AMP_W + GAIN_W)'(gain_new);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_amp_q   <= prod[FRAC_W +: AMP_W];
      out_phase_q <= s1_phase_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tdata = {out_phase_q, out_amp_q};
  assign m_axis_tlast = out_last_q;

endmodule

// ----- rtl/sbg_checker.sv -----
`timescale 1ns / 1ps

module sbg_checker
  import sbg_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [APB_AW-1:0]  paddr,
  input logic [APB_DW-1:0]  pwdata,
  input logic [APB_DW-1:0]  prdata,
  input logic               pready
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  else $error("result changed while stalled");

  // with the result register empty the block always has room for a bin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
  else $error("input blocked with empty output");

  // a threshold write reads back on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[3:2] == REG_THRESHOLD) |=>
      (paddr[3:2] != REG_THRESHOLD) ||
      (prdata == APB_DW'($past(pwdata[THR_W-1:0]))))
  else $error("threshold readback mismatch");

endmodule

bind spectral_bin_gate sbg_checker u_sbg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import sbg_pkg::*;

  localparam int unsigned BIN_COUNT = 1024;

  localparam logic [APB_AW-1:0] ADDR_THR      = {REG_THRESHOLD, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_ATTACK   = {REG_ATTACK, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_DECAY    = {REG_DECAY, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED = 4'hC;

  typedef struct packed {
    logic [AMP_W-1:0]   amp;
    logic [PHASE_W-1:0] phase;
    logic               last;
  } gated_bin_t;

  typedef struct packed {
    logic [AMP_W-1:0]   amp;
    logic [PHASE_W-1:0] phase;
    logic               last;
    logic               typed;
    logic [AMP_W-1:0]   want_amp;
  } bin_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // [23:0] amplitude, [47:24] phase
  logic               s_axis_tlast = 1'b0; // last_bin
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // [23:0] gated_amplitude, [47:24] phase_out
  logic               m_axis_tlast;        // last_out
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  spectral_bin_gate #(
    .MAX_BINS(BIN_COUNT)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // model of the gate state
  logic [THR_W-1:0]  thr_cfg = '0;
  logic [GAIN_W-1:0] attack_cfg = GAIN_ONE;
  logic [GAIN_W-1:0] decay_cfg = GAIN_ONE;
  logic [GAIN_W-1:0] gain_mem [BIN_COUNT];
  int unsigned       bin_pos = 0;

  gated_bin_t gated_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left = 0;

  // directed bins, reset configuration: threshold 0, unity steps
  bin_row_t dir_rows [0:13] = '{
    '{24'hFFFFFF, 24'h7FFFFF, 1'b0, 1'b1, 24'hFFFFFF}, // bin 0 jumps to unity
    '{24'h000000, 24'h800000, 1'b0, 1'b1, 24'h000000}, // bin 1 held at zero
    '{24'h000001, 24'h000001, 1'b1, 1'b1, 24'h000001}, // frame end
    '{24'h000000, 24'hFFFFFF, 1'b0, 1'b1, 24'h000000}, // bin 0 decays to zero
    '{24'hFFFFFF, 24'h000000, 1'b0, 1'b1, 24'hFFFFFF},
    '{24'hFFFFFF, 24'h555555, 1'b0, 1'b1, 24'hFFFFFF}, // bin 2 already at unity
    '{24'h800000, 24'hAAAAAA, 1'b1, 1'b1, 24'h800000},
    '{24'h000000, 24'h123456, 1'b1, 1'b1, 24'h000000}, // one-bin frames
    '{24'h000000, 24'h654321, 1'b1, 1'b1, 24'h000000},
    '{24'hABCDEF, 24'h0F0F0F, 1'b0, 1'b0, 24'h000000},
    '{24'h000002, 24'hF0F0F0, 1'b0, 1'b0, 24'h000000},
    '{24'h7FFFFF, 24'h3C3C3C, 1'b0, 1'b0, 24'h000000},
    '{24'hFFFFFE, 24'hC3C3C3, 1'b0, 1'b0, 24'h000000},
    '{24'h000001, 24'h000000, 1'b1, 1'b0, 24'h000000}
  };

  function automatic gated_bin_t gate_bin(input logic [AMP_W-1:0] amp,
                                          input logic [PHASE_W-1:0] phase,
                                          input logic last);
    int unsigned g;
    logic [40:0] prod;
    gated_bin_t res;
    g = gain_mem[bin_pos];
    if (amp > thr_cfg) begin
      if (g < GAIN_ONE) begin
        g = g + attack_cfg;
        if (g > GAIN_ONE) g = GAIN_ONE;
      end
    end else begin
      g = (g > decay_cfg) ? g - decay_cfg : 0;
    end
    gain_mem[bin_pos] = g[GAIN_W-1:0];
    prod = 41'(amp) * 41'(g);
    res.amp = prod[FRAC_W +: AMP_W];
    res.phase = phase;
    res.last = last;
    bin_pos = (last || bin_pos == BIN_COUNT - 1) ? 0 : bin_pos + 1;
    return res;
  endfunction

  function automatic logic [AMP_W-1:0] pick_amp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return thr_cfg;
      3: return thr_cfg + 1'b1;
      4, 5: return AMP_W'($urandom);
      default: return thr_cfg + AMP_W'($urandom_range(0, 64)) - AMP_W'(32);
    endcase
  endfunction

  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_THR) thr_cfg = data[THR_W-1:0];
    else if (addr == ADDR_ATTACK) attack_cfg = data[GAIN_W-1:0];
    else if (addr == ADDR_DECAY) decay_cfg = data[GAIN_W-1:0];
  endtask

  task automatic send_bin(input logic [AMP_W-1:0] amp, input logic [PHASE_W-1:0] phase,
                          input logic last, input logic typed,
                          input logic [AMP_W-1:0] want_amp);
    int unsigned gap;
    gated_bin_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {phase, amp};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    res = gate_bin(amp, phase, last);
    if (typed) res.amp = want_amp;
    gated_q.push_back(res);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (gated_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: the stall pattern is re-drawn at random from four modes
  logic [1:0]  stall_mode = 2'd0;
  int unsigned stall_cyc = 0;

  always @(posedge clk_i) begin
    gated_bin_t want;
    gated_bin_t got;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = {m_axis_tdata[AMP_W-1:0], m_axis_tdata[TDATA_W-1:AMP_W], m_axis_tlast};
      if (gated_q.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, got);
        mismatch_cnt++;
      end else begin
        want = gated_q.pop_front();
        if (got.amp !== want.amp) begin
          $display("%0t: gated_amplitude expected %h actual %h", $time, want.amp, got.amp);
          mismatch_cnt++;
        end
        if (got.phase !== want.phase) begin
          $display("%0t: phase_out expected %h actual %h", $time, want.phase, got.phase);
          mismatch_cnt++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_out expected %b actual %b", $time, want.last, got.last);
          mismatch_cnt++;
        end
      end
    end
    stall_cyc++;
    if (stall_cyc % 64 == 0) stall_mode = 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_cyc % 7 < 3);
    endcase
  end

  initial begin
    logic [THR_W-1:0]  t;
    logic [GAIN_W-1:0] a;
    logic [GAIN_W-1:0] d;
    int unsigned sent;
    int unsigned flen;
    foreach (gain_mem[i]) gain_mem[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_bin(dir_rows[i].amp, dir_rows[i].phase, dir_rows[i].last,
               dir_rows[i].typed, dir_rows[i].want_amp);
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin t = '0; a = 17'd1; d = 17'd1; end
        1: begin t = '1; a = GAIN_ONE; d = GAIN_ZERO; end
        2: begin t = 24'h800000; a = '1; d = '1; end           // steps above unity
        3: begin
          t = THR_W'($urandom);
          a = GAIN_ZERO;
          d = GAIN_W'($urandom_range(1, 65536));
        end
        4: begin
          t = THR_W'($urandom);
          a = GAIN_W'($urandom_range(0, 65536));
          d = GAIN_W'($urandom_range(0, 65536));
        end
        5: begin t = 24'd1000; a = 17'd16384; d = 17'd4096; end
        6: begin
          t = THR_W'($urandom);
          a = GAIN_W'($urandom_range(0, 131071));
          d = GAIN_W'($urandom_range(0, 131071));
        end
        default: begin t = THR_W'($urandom); a = 17'd8192; d = 17'd8192; end
      endcase
      cfg_write(ADDR_THR, {8'($urandom), t});
      cfg_write(ADDR_ATTACK, {15'($urandom), a});
      cfg_write(ADDR_DECAY, {15'($urandom), d});
      if (ph == 3) cfg_write(ADDR_UNMAPPED, $urandom);

      if (ph == 7) begin
        // no frame mark for more than a full bin range, so the counter wraps
        for (int k = 0; k < BIN_COUNT + 6; k++)
          send_bin(pick_amp(), PHASE_W'($urandom), k == BIN_COUNT + 5, 1'b0, '0);
      end else begin
        sent = 0;
        while (sent < 125) begin
          flen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          for (int k = 0; k < flen; k++) begin
            send_bin(pick_amp(), PHASE_W'($urandom), k == flen - 1, 1'b0, '0);
            sent++;
          end
        end
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
